// ===== src/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the page access hotness tracker
// Holds the action and status codes, field widths, default parameter values
// and the recency decay table used by the heat score.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int BUCKETS_DEF    = 256;
	localparam int WAYS_DEF       = 4;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int ADDR_W = 48;
	localparam int TIME_W = 48;
	localparam int CNT_W  = 32;
	localparam int HEAT_W = 16;
	localparam int TRK_W  = 11;

	localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

	localparam logic [1:0] ACT_RECORD = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_CREATED = 2'd1;
	localparam logic [1:0] ST_NOTRK   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// Divider operand widths: the dividend is a 62-bit product, the divisor a time.
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 48;

	localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
	localparam logic [9:0]  FREQ_SCALE  = 10'd1000;
	localparam logic [15:0] W_RECENCY   = 16'd39322;
	localparam logic [15:0] W_FREQ      = 16'd26214;

	// ceil(2^36 / 1000): for a rate below 1000, (rate * FREQ_RECIP) >> 20 equals
	// floor(rate * 65536 / 1000) exactly.
	localparam logic [26:0] FREQ_RECIP  = 27'd68719477;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef logic [255:0][15:0] rom_t;

	// round(65535*exp(-0.07*i*2^30/1e9)) in Q62 fixed point, worked out at elaboration.
	function automatic rom_t build_recency();
		rom_t         rom;
		logic [63:0]  num;
		logic [63:0]  den;
		logic [63:0]  step;
		logic [63:0]  term;
		logic [63:0]  pos;
		logic [63:0]  neg;
		logic [63:0]  decay;
		logic [63:0]  p;
		logic [63:0]  v;
		logic [127:0] w;
		num  = 64'd7516192768;
		den  = 64'd100000000000;
		step = '0;
		term = 64'h4000000000000000;
		pos  = 64'h4000000000000000;
		neg  = '0;
		for (int k = 0; k < 62; k++) begin
			num  = num << 1;
			step = step << 1;
			if (num >= den) begin
				num     = num - den;
				step[0] = 1'b1;
			end
		end
		for (int k = 1; k <= 24; k++) begin
			w    = 128'(term) * 128'(step);
			term = 64'(w >> 62) / 64'(k);
			if (k[0])
				neg = neg + term;
			else
				pos = pos + term;
		end
		decay = pos - neg;
		p     = 64'h4000000000000000;
		for (int k = 0; k < 256; k++) begin
			w      = 128'(p) * 128'd65535;
			v      = 64'(w >> 62) + 64'(w[61]);
			rom[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			w      = 128'(p) * 128'(decay);
			p      = 64'(w >> 62);
		end
		return rom;
	endfunction

	localparam rom_t RECENCY_ROM = build_recency();

endpackage

// ===== src/pat_ram.sv =====
// ----------------------------------------------------------------------------
// pat_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== src/pat_div.sv =====
// ----------------------------------------------------------------------------
// pat_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module pat_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pat_pkg::div_req_t req,
	output pat_pkg::div_rsp_t rsp
);

	localparam int NW = pat_pkg::DIV_NUM_W;
	localparam int DW = pat_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== src/page_access_hotness_tracker.sv =====
// ----------------------------------------------------------------------------
// page_access_hotness_tracker: hashed page access counter table
// Records page accesses in a set-associative table held in one RAM row per
// bucket, and answers queries with counters, access rate and heat score.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall  | action, address, write_access, now_ns
//  out     | output    | out_valid/out_stall| status, access_total, read_total,
//          |           |                    | write_total, rate_per_second, heat,
//          |           |                    | pages_tracked
//
// A record, a query miss or an unused action steps from one accepted transfer
// to the next through accept, bucket read, and compare with write back; the
// single RAM read and write of the bucket row sets these steps. The result is
// offered from the cycle after the compare.
// A query hit goes on to multiply, start and wait on the one-bit-per-cycle rate
// divider, frequency, heat and final steps; a zero lifetime skips the divider.
// A clear, and the clearing pass after reset, sweep all BUCKETS rows at one row
// per cycle, during which in_stall is high.
// A waiting result stalls only the final step of the next item; the next item
// may be accepted while out_valid is high.
module page_access_hotness_tracker #(
	parameter int BUCKETS    = pat_pkg::BUCKETS_DEF,
	parameter int WAYS       = pat_pkg::WAYS_DEF,
	parameter int PAGE_SHIFT = pat_pkg::PAGE_SHIFT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [pat_pkg::ADDR_W-1:0]  address,
	input  logic                        write_access,
	input  logic [pat_pkg::TIME_W-1:0]  now_ns,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [pat_pkg::CNT_W-1:0]   access_total,
	output logic [pat_pkg::CNT_W-1:0]   read_total,
	output logic [pat_pkg::CNT_W-1:0]   write_total,
	output logic [pat_pkg::CNT_W-1:0]   rate_per_second,
	output logic [pat_pkg::HEAT_W-1:0]  heat,
	output logic [pat_pkg::TRK_W-1:0]   pages_tracked
);

	localparam int PAGE_W  = pat_pkg::ADDR_W - PAGE_SHIFT;
	localparam int BKT_W   = $clog2(BUCKETS);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOTS   = BUCKETS * WAYS;
	localparam int VC_W    = $clog2(SLOTS + 1);
	localparam int CW      = pat_pkg::CNT_W;
	localparam int TW      = pat_pkg::TIME_W;

	// Sequencer state codes.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_CMP  = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_DIVA = 4'd5;
	localparam logic [3:0] S_DIVW = 4'd6;
	localparam logic [3:0] S_FREQ = 4'd7;
	localparam logic [3:0] S_HEAT = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	typedef struct packed {
		logic              vld;
		logic [PAGE_W-1:0] page;
		logic [CW-1:0]     acc;
		logic [CW-1:0]     rd;
		logic [CW-1:0]     wr;
		logic [TW-1:0]     created;
		logic [TW-1:0]     last;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	// Control state.
	logic [3:0]       state_q;
	logic [BKT_W-1:0] clr_idx_q;
	logic             clr_report_q;
	logic [VC_W-1:0]  vcount_q;
	logic             out_valid_q;

	// Item registers.
	logic [1:0]        action_q;
	logic [PAGE_W-1:0] page_q;
	logic              write_access_q;
	logic [TW-1:0]     now_q;
	logic [BKT_W-1:0]  bucket_q;

	// Query working registers.
	logic [CW-1:0]  acc_q;
	logic [CW-1:0]  rd_q;
	logic [CW-1:0]  wr_q;
	logic [TW-1:0]  life_q;
	logic [7:0]     ridx_q;
	logic [61:0]    prod_q;
	logic [CW-1:0]  rate_q;
	logic [15:0]    freq_q;
	logic [31:0]    hp_rec_q;
	logic [31:0]    hp_frq_q;

	// Output registers.
	logic [1:0]                 status_q;
	logic [CW-1:0]              acc_out_q;
	logic [CW-1:0]              rd_out_q;
	logic [CW-1:0]              wr_out_q;
	logic [CW-1:0]              rate_out_q;
	logic [pat_pkg::HEAT_W-1:0] heat_out_q;
	logic [pat_pkg::TRK_W-1:0]  trk_out_q;

	logic              accept;
	logic              out_free;
	logic [PAGE_W-1:0] in_page;
	logic [2*BKT_W-1:0] hash_prod;

	logic             ram_we;
	logic [BKT_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic             ram_re;
	logic [ROW_W-1:0] ram_rdata_w;
	row_t             row;
	row_t             wrow;

	logic [WAYS-1:0]  hit_vec;
	logic [WAYS-1:0]  free_vec;
	logic             hit;
	logic             has_free;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] sel_way;
	way_t             base_way;
	way_t             new_way;
	logic [TW-1:0]    life_c;
	logic [TW-1:0]    idle_c;

	logic [35:0]      freq_prod;
	logic [32:0]      heat_sum;
	pat_pkg::div_req_t div_req;
	pat_pkg::div_rsp_t div_rsp;

	logic             emit;
	logic [1:0]       e_status;
	logic [CW-1:0]    e_acc;
	logic [CW-1:0]    e_rd;
	logic [CW-1:0]    e_wr;
	logic [CW-1:0]    e_rate;
	logic [15:0]      e_heat;
	logic [VC_W-1:0]  e_vcount;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Multiplicative hash: only the low BKT_W bits of the product are kept,
	// so only the low bits of page and multiplier take part.
	assign in_page   = PAGE_W'(address >> PAGE_SHIFT);
	assign hash_prod = in_page[BKT_W-1:0] * pat_pkg::HASH_MUL[BKT_W-1:0];

	assign row = row_t'(ram_rdata_w);

	pat_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(bucket_q),
		.rdata(ram_rdata_w)
	);

	pat_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Way lookup over the bucket row: lowest matching way, lowest free way.
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		hit      = 1'b0;
		has_free = 1'b0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			hit_vec[w]  = row[w].vld && (row[w].page == page_q);
			free_vec[w] = !row[w].vld;
			if (hit_vec[w]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (free_vec[w]) begin
				has_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		sel_way = hit ? hit_way : free_way;
		base_way = row[sel_way];
		if (!hit) begin
			base_way.vld     = 1'b1;
			base_way.page    = page_q;
			base_way.acc     = '0;
			base_way.rd      = '0;
			base_way.wr      = '0;
			base_way.created = now_q;
		end
		new_way      = base_way;
		new_way.acc  = sat_inc(base_way.acc);
		new_way.rd   = write_access_q ? base_way.rd : sat_inc(base_way.rd);
		new_way.wr   = write_access_q ? sat_inc(base_way.wr) : base_way.wr;
		new_way.last = now_q;
		wrow          = row;
		wrow[sel_way] = new_way;
		life_c = (now_q >= row[hit_way].created) ? now_q - row[hit_way].created : '0;
		idle_c = (now_q >= row[hit_way].last) ? now_q - row[hit_way].last : '0;
	end

	// Frequency by reciprocal multiplication; only used when the rate is below 1000.
	assign freq_prod = rate_q[9:0] * pat_pkg::FREQ_RECIP;

	assign heat_sum = 33'(hp_rec_q) + 33'(hp_frq_q);

	// Sequencer outputs: RAM access, divider start and result composition.
	always_comb begin
		ram_re    = (state_q == S_RD);
		ram_we    = 1'b0;
		ram_waddr = bucket_q;
		ram_wdata = ROW_W'(wrow);
		div_req   = '0;
		emit      = 1'b0;
		e_status  = pat_pkg::ST_NOTRK;
		e_acc     = '0;
		e_rd      = '0;
		e_wr      = '0;
		e_rate    = '0;
		e_heat    = '0;
		e_vcount  = vcount_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
				if (clr_idx_q == BKT_W'(BUCKETS - 1) && clr_report_q && out_free) begin
					emit     = 1'b1;
					e_status = pat_pkg::ST_FOUND;
					e_vcount = '0;
				end
			end
			S_CMP: begin
				if (action_q == pat_pkg::ACT_RECORD) begin
					if (out_free) begin
						emit = 1'b1;
						if (hit || has_free) begin
							ram_we   = 1'b1;
							e_status = hit ? pat_pkg::ST_FOUND : pat_pkg::ST_CREATED;
							e_acc    = new_way.acc;
							e_rd     = new_way.rd;
							e_wr     = new_way.wr;
							e_vcount = hit ? vcount_q : vcount_q + 1'b1;
						end else begin
							e_status = pat_pkg::ST_FULL;
						end
					end
				end else if (!(action_q == pat_pkg::ACT_QUERY && hit)) begin
					emit = out_free;
				end
			end
			S_DIVA: begin
				div_req.start = (life_q != '0);
				div_req.num   = pat_pkg::DIV_NUM_W'(prod_q);
				div_req.den   = life_q;
			end
			S_FIN: begin
				emit     = out_free;
				e_status = pat_pkg::ST_FOUND;
				e_acc    = acc_q;
				e_rd     = rd_q;
				e_wr     = wr_q;
				e_rate   = rate_q;
				e_heat   = (heat_sum[32:16] > 17'd65535) ? 16'hFFFF : heat_sum[31:16];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_idx_q    <= '0;
			clr_report_q <= 1'b0;
			vcount_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			if (emit)
				vcount_q <= e_vcount;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == pat_pkg::ACT_CLEAR) begin
							state_q      <= S_CLR;
							clr_idx_q    <= '0;
							clr_report_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_CLR: begin
					if (clr_idx_q != BKT_W'(BUCKETS - 1))
						clr_idx_q <= clr_idx_q + 1'b1;
					else if (!clr_report_q) begin
						vcount_q <= '0;
						state_q  <= S_IDLE;
					end else if (emit)
						state_q <= S_IDLE;
				end
				S_RD:   state_q <= S_CMP;
				S_CMP: begin
					if (emit)
						state_q <= S_IDLE;
					else if (action_q == pat_pkg::ACT_QUERY && hit)
						state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_DIVA;
				S_DIVA: state_q <= (life_q != '0) ? S_DIVW : S_FREQ;
				S_DIVW: begin
					if (div_rsp.done)
						state_q <= S_FREQ;
				end
				S_FREQ: state_q <= S_HEAT;
				S_HEAT: state_q <= S_FIN;
				S_FIN: begin
					if (emit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q       <= action;
			page_q         <= in_page;
			write_access_q <= write_access;
			now_q          <= now_ns;
			bucket_q       <= hash_prod[BKT_W-1:0];
		end
		if (state_q == S_CMP) begin
			acc_q  <= row[hit_way].acc;
			rd_q   <= row[hit_way].rd;
			wr_q   <= row[hit_way].wr;
			life_q <= life_c;
			ridx_q <= (idle_c[TW-1:38] != '0) ? 8'hFF : idle_c[37:30];
		end
		if (state_q == S_MUL)
			prod_q <= 62'(acc_q) * 62'(pat_pkg::NS_PER_SEC);
		if (state_q == S_DIVA && life_q == '0)
			rate_q <= '0;
		if (state_q == S_DIVW && div_rsp.done)
			rate_q <= (div_rsp.quo[63:32] != '0) ? '1 : div_rsp.quo[31:0];
		if (state_q == S_FREQ)
			freq_q <= (rate_q < CW'(pat_pkg::FREQ_SCALE)) ? freq_prod[35:20] : 16'hFFFF;
		if (state_q == S_HEAT) begin
			hp_rec_q <= pat_pkg::W_RECENCY * pat_pkg::RECENCY_ROM[ridx_q];
			hp_frq_q <= pat_pkg::W_FREQ * freq_q;
		end
		if (emit) begin
			status_q   <= e_status;
			acc_out_q  <= e_acc;
			rd_out_q   <= e_rd;
			wr_out_q   <= e_wr;
			rate_out_q <= e_rate;
			heat_out_q <= e_heat;
			trk_out_q  <= pat_pkg::TRK_W'(e_vcount);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign access_total    = acc_out_q;
	assign read_total      = rd_out_q;
	assign write_total     = wr_out_q;
	assign rate_per_second = rate_out_q;
	assign heat            = heat_out_q;
	assign pages_tracked   = trk_out_q;

	// The table never counts more entries than it has slots.
	a_vcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= VC_W'(SLOTS))
		else $error("valid entry count exceeds table size");

	// An idle sequencer never writes the table.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("table written while idle");

	// The divider is only started when the sequencer moves on to the state that waits for it.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> (state_q == S_DIVW))
		else $error("divider started without a waiting state");

	// A result is only produced while the previous one can be replaced.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrote an untaken result");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the page access hotness tracker
// Drives records, queries, clears and unused action codes with random idling
// on both channels. Each accepted transfer is predicted by a scoreboard that
// keeps its own copy of the hashed way table, and each result transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int  N_BUCKETS   = pat_pkg::BUCKETS_DEF;
	localparam int  N_WAYS      = pat_pkg::WAYS_DEF;
	localparam int  N_SLOTS     = N_BUCKETS * N_WAYS;
	localparam int  PG_SHIFT    = pat_pkg::PAGE_SHIFT_DEF;
	localparam int  ADDR_W      = pat_pkg::ADDR_W;
	localparam int  TIME_W      = pat_pkg::TIME_W;
	localparam int  CNT_W       = pat_pkg::CNT_W;
	localparam int  HEAT_W      = pat_pkg::HEAT_W;
	localparam int  TRK_W       = pat_pkg::TRK_W;
	localparam int  PAGE_W      = ADDR_W - PG_SHIFT;
	localparam int  RANDOM_ITEMS = 730;
	localparam longint CYCLE_LIMIT = 2000000;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        status;
		logic [CNT_W-1:0]  access_total;
		logic [CNT_W-1:0]  read_total;
		logic [CNT_W-1:0]  write_total;
		logic [CNT_W-1:0]  rate_per_second;
		logic [HEAT_W-1:0] heat;
		logic [TRK_W-1:0]  pages_tracked;
	} page_result_t;

	// Bucket that a page number lands in, by the wrapping multiplicative hash.
	function automatic int bucket_of(logic [PAGE_W-1:0] page);
		logic [63:0] prod;
		prod = 64'(page) * pat_pkg::HASH_MUL;
		return int'(prod % 64'(N_BUCKETS));
	endfunction

	// The scoreboard mirrors the table and holds the results still owed.
	class hotness_scoreboard;
		logic [15:0]        decay_table [256];
		bit                 slot_valid [N_SLOTS];
		logic [PAGE_W-1:0]  slot_page [N_SLOTS];
		logic [CNT_W-1:0]   slot_acc [N_SLOTS];
		logic [CNT_W-1:0]   slot_rd [N_SLOTS];
		logic [CNT_W-1:0]   slot_wr [N_SLOTS];
		logic [TIME_W-1:0]  slot_born [N_SLOTS];
		logic [TIME_W-1:0]  slot_seen [N_SLOTS];
		int unsigned        live_pages;
		page_result_t       owed [$];
		int unsigned        mismatches;

		function new();
			logic [63:0]  num;
			logic [63:0]  step;
			logic [63:0]  term;
			logic [63:0]  pos;
			logic [63:0]  neg;
			logic [63:0]  decay;
			logic [63:0]  p;
			logic [63:0]  v;
			logic [127:0] prod;
			// Q62 step = 0.07 * 2^30 / 1e9, then exp(-step) by its Taylor series.
			num  = 64'd7516192768;
			step = '0;
			for (int k = 0; k < 62; k++) begin
				num  = num << 1;
				step = step << 1;
				if (num >= 64'd100000000000) begin
					num     = num - 64'd100000000000;
					step[0] = 1'b1;
				end
			end
			term = 64'd1 << 62;
			pos  = term;
			neg  = '0;
			for (int k = 1; k <= 24; k++) begin
				prod = 128'(term) * 128'(step);
				term = prod[125:62] / 64'(k);
				if (k % 2 == 1)
					neg += term;
				else
					pos += term;
			end
			decay = pos - neg;
			p     = 64'd1 << 62;
			for (int i = 0; i < 256; i++) begin
				prod = 128'(p) * 128'd65535;
				v    = prod[125:62] + 64'(prod[61]);
				decay_table[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
				prod = 128'(p) * 128'(decay);
				p    = prod[125:62];
			end
			foreach (slot_valid[i])
				slot_valid[i] = 0;
			live_pages = 0;
			mismatches = 0;
		endfunction

		function int find_way(int base, logic [PAGE_W-1:0] page);
			for (int w = 0; w < N_WAYS; w++)
				if (slot_valid[base + w] && slot_page[base + w] == page)
					return base + w;
			return -1;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		// Works out the result of one accepted input transfer.
		function void note_request(logic [1:0] act, logic [ADDR_W-1:0] addr, bit wr,
				logic [TIME_W-1:0] now);
			page_result_t      r;
			logic [PAGE_W-1:0] page;
			int                base;
			int                s;
			logic [63:0]       life;
			logic [63:0]       idle;
			logic [63:0]       rate;
			logic [63:0]       freq;
			logic [63:0]       idx;
			logic [63:0]       h;
			r    = '0;
			r.status = pat_pkg::ST_NOTRK;
			page = addr[ADDR_W-1:PG_SHIFT];
			base = bucket_of(page) * N_WAYS;
			case (act)
				pat_pkg::ACT_RECORD: begin
					s = find_way(base, page);
					r.status = pat_pkg::ST_FOUND;
					if (s < 0) begin
						for (int w = 0; w < N_WAYS; w++)
							if (s < 0 && !slot_valid[base + w])
								s = base + w;
						if (s >= 0) begin
							slot_valid[s] = 1;
							slot_page[s]  = page;
							slot_acc[s]   = '0;
							slot_rd[s]    = '0;
							slot_wr[s]    = '0;
							slot_born[s]  = now;
							live_pages++;
							r.status = pat_pkg::ST_CREATED;
						end else begin
							r.status = pat_pkg::ST_FULL;
						end
					end
					if (s >= 0) begin
						slot_acc[s] = bump(slot_acc[s]);
						if (wr)
							slot_wr[s] = bump(slot_wr[s]);
						else
							slot_rd[s] = bump(slot_rd[s]);
						slot_seen[s] = now;
						r.access_total = slot_acc[s];
						r.read_total   = slot_rd[s];
						r.write_total  = slot_wr[s];
					end
				end
				pat_pkg::ACT_QUERY: begin
					s = find_way(base, page);
					if (s >= 0) begin
						r.status       = pat_pkg::ST_FOUND;
						r.access_total = slot_acc[s];
						r.read_total   = slot_rd[s];
						r.write_total  = slot_wr[s];
						// Time that runs backwards counts as no time at all.
						life = (now >= slot_born[s]) ? 64'(now - slot_born[s]) : 64'd0;
						rate = 0;
						if (life != 0) begin
							rate = (64'(slot_acc[s]) * 64'd1000000000) / life;
							if (rate > 64'hFFFFFFFF)
								rate = 64'hFFFFFFFF;
						end
						idle = (now >= slot_seen[s]) ? 64'(now - slot_seen[s]) : 64'd0;
						idx  = idle >> 30;
						if (idx > 255)
							idx = 255;
						freq = (rate * 64'd65536) / 64'd1000;
						if (freq > 65535)
							freq = 65535;
						h = (64'd39322 * 64'(decay_table[idx[7:0]]) + 64'd26214 * freq) >> 16;
						if (h > 65535)
							h = 65535;
						r.rate_per_second = rate[31:0];
						r.heat            = h[15:0];
					end
				end
				pat_pkg::ACT_CLEAR: begin
					foreach (slot_valid[i])
						slot_valid[i] = 0;
					live_pages = 0;
					r.status   = pat_pkg::ST_FOUND;
				end
				default: ;
			endcase
			r.pages_tracked = live_pages[TRK_W-1:0];
			owed.push_back(r);
		endfunction

		function void check_result(page_result_t got);
			page_result_t want;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing outstanding: %p", got);
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status || got.access_total !== want.access_total ||
					got.read_total !== want.read_total ||
					got.write_total !== want.write_total ||
					got.rate_per_second !== want.rate_per_second ||
					got.heat !== want.heat || got.pages_tracked !== want.pages_tracked) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result mismatch at %0t", $realtime);
					$display("  expected %p", want);
					$display("  actual   %p", got);
				end
			end
		endfunction

		function int outstanding();
			return owed.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          action;
	logic [ADDR_W-1:0]   address;
	logic                write_access;
	logic [TIME_W-1:0]   now_ns;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [CNT_W-1:0]    access_total;
	logic [CNT_W-1:0]    read_total;
	logic [CNT_W-1:0]    write_total;
	logic [CNT_W-1:0]    rate_per_second;
	logic [HEAT_W-1:0]   heat;
	logic [TRK_W-1:0]    pages_tracked;

	hotness_scoreboard   sb;
	longint              cycles;
	bit                  no_idle;
	int                  resp_wait;
	int                  long_hold;
	logic [TIME_W-1:0]   clock_ns;
	logic [PAGE_W-1:0]   page_pool [$];

	page_access_hotness_tracker u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.address         (address),
		.write_access    (write_access),
		.now_ns          (now_ns),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.access_total    (access_total),
		.read_total      (read_total),
		.write_total     (write_total),
		.rate_per_second (rate_per_second),
		.heat            (heat),
		.pages_tracked   (pages_tracked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The watchdog ends a hung run; the limit is far beyond the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("page_access_hotness_tracker regression: fail");
			$finish;
		end
	end

	// Result monitor: every output transfer is checked, then the next wait is drawn.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result({status, access_total, read_total, write_total,
				rate_per_second, heat, pages_tracked});
			resp_wait <= no_idle ? 0 : $urandom_range(0, 13);
		end
	end

	// Receiver side: stall for the drawn wait, or for a long hold-off when asked.
	// The long hold-off lets the tracker fill up and push back on its input.
	always @(negedge clk) begin
		if (long_hold > 0) begin
			out_stall <= 1'b1;
			long_hold <= long_hold - 1;
		end else if (resp_wait > 0) begin
			out_stall <= 1'b1;
			resp_wait <= resp_wait - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Offers one request and returns once the transfer has happened. A gap of
	// zero keeps in_valid high, so the next payload follows back to back.
	task automatic send_request(logic [1:0] act, logic [ADDR_W-1:0] addr, bit wr,
			logic [TIME_W-1:0] now);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		action       = act;
		address      = addr;
		write_access = wr;
		now_ns       = now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(act, addr, wr, now);
	endtask

	function automatic logic [ADDR_W-1:0] addr_in_page(logic [PAGE_W-1:0] page);
		return {page, PG_SHIFT'($urandom)};
	endfunction

	function automatic logic [PAGE_W-1:0] random_page();
		return {4'($urandom), 32'($urandom)};
	endfunction

	// Draws pages until one falls in the wanted bucket, to force way conflicts.
	function automatic logic [PAGE_W-1:0] page_for_bucket(int b);
		logic [PAGE_W-1:0] pg;
		pg = random_page();
		while (bucket_of(pg) != b)
			pg = random_page();
		return pg;
	endfunction

	// Moves the time stamp on: mostly small steps, sometimes long idle times,
	// now and then a step back or a jump anywhere.
	function automatic logic [TIME_W-1:0] next_time();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			clock_ns = clock_ns + $urandom_range(0, 40);
		else if (sel < 85)
			clock_ns = clock_ns + $urandom_range(0, 200000);
		else if (sel < 94)
			clock_ns = clock_ns + (48'd1 << 30) * $urandom_range(1, 300);
		else if (sel < 98)
			clock_ns = clock_ns - $urandom_range(1, 5000);
		else
			clock_ns = {16'($urandom), 32'($urandom)};
		return clock_ns;
	endfunction

	initial begin
		logic [PAGE_W-1:0] pg;
		logic [PAGE_W-1:0] crowd [5];
		int                sel;
		int                b;
		sb           = new();
		cycles       = 0;
		no_idle      = 0;
		resp_wait    = 0;
		long_hold    = 0;
		clock_ns     = '0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = pat_pkg::ACT_RECORD;
		address      = '0;
		write_access = 1'b0;
		now_ns       = '0;
		out_stall    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A zero lifetime gives a zero rate.
		send_request(pat_pkg::ACT_RECORD, '0, 1'b0, '0);
		send_request(pat_pkg::ACT_QUERY, '0, 1'b0, '0);
		send_request(pat_pkg::ACT_RECORD, '1, 1'b1, 48'd5);
		send_request(pat_pkg::ACT_RECORD, '1, 1'b0, 48'd6);
		// A one nanosecond lifetime gives a large rate that saturates the frequency term.
		send_request(pat_pkg::ACT_QUERY, '1, 1'b0, 48'd6);
		send_request(pat_pkg::ACT_QUERY, {36'h123456789, 12'h000}, 1'b0, 48'd7);
		// Five pages on one bucket: four take the ways, the fifth is dropped.
		b = $urandom_range(0, N_BUCKETS - 1);
		for (int i = 0; i < 5; i++) begin
			crowd[i] = page_for_bucket(b);
			while (i > 0 && crowd[i] == crowd[0])
				crowd[i] = page_for_bucket(b);
			send_request(pat_pkg::ACT_RECORD, addr_in_page(crowd[i]), i[0], 48'd100 + i);
		end
		send_request(pat_pkg::ACT_QUERY, addr_in_page(crowd[4]), 1'b0, 48'd200);
		send_request(pat_pkg::ACT_QUERY, addr_in_page(crowd[2]), 1'b0, 48'd300000);
		// Time going backwards, then an idle time past the end of the decay table.
		send_request(pat_pkg::ACT_QUERY, addr_in_page(crowd[3]), 1'b0, 48'd10);
		send_request(pat_pkg::ACT_QUERY, addr_in_page(crowd[1]), 1'b0, '1);
		send_request(pat_pkg::ACT_RECORD, addr_in_page(crowd[0]), 1'b1, '1);
		send_request(ACT_UNUSED, '1, 1'b1, '1);
		send_request(pat_pkg::ACT_CLEAR, '0, 1'b0, '1);
		send_request(pat_pkg::ACT_QUERY, addr_in_page(crowd[0]), 1'b0, '1);
		send_request(pat_pkg::ACT_RECORD, addr_in_page(crowd[4]), 1'b0, 48'd0);

		// Page pool: crowded buckets for conflicts plus scattered pages.
		for (int g = 0; g < 3; g++) begin
			b = $urandom_range(0, N_BUCKETS - 1);
			for (int i = 0; i < 6; i++)
				page_pool.push_back(page_for_bucket(b));
		end
		for (int i = 0; i < 14; i++)
			page_pool.push_back(random_page());
		clock_ns = 48'd1000;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			// Long receiver hold-off while requests keep coming.
			if (n == 200 || n == 500)
				long_hold = 400;
			sel = $urandom_range(0, 99);
			pg  = ($urandom_range(0, 4) == 0) ? random_page()
				: page_pool[$urandom_range(0, page_pool.size() - 1)];
			if (sel < 70)
				send_request(pat_pkg::ACT_RECORD, addr_in_page(pg), 1'($urandom),
					next_time());
			else if (sel < 93)
				send_request(pat_pkg::ACT_QUERY, addr_in_page(pg), 1'($urandom),
					next_time());
			else if (sel < 96)
				send_request(pat_pkg::ACT_CLEAR, {16'($urandom), 32'($urandom)},
					1'($urandom), next_time());
			else
				send_request(ACT_UNUSED, {16'($urandom), 32'($urandom)}, 1'($urandom),
					next_time());
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("page_access_hotness_tracker regression: pass");
		else
			$display("page_access_hotness_tracker regression: fail");
		$finish;
	end

endmodule
